// ===== design/sacl_pkg.sv =====
// shared types, constants and helpers of the set-associative cache lookup
`default_nettype none

package sacl_pkg;

   // tag store entry: valid bit over the tag
   localparam int ENTRY_W = 31;
   localparam int TAG_W   = 30;

   // widest index_bits the set field can carry
   localparam int IDX_CAP = 8;

   // length and block size counts, up to 64
   localparam int LEN_W = 7;

   // csr port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // register indexes
   localparam logic [1:0] REG_OFFSET_BITS  = 2'd0;
   localparam logic [1:0] REG_INDEX_BITS   = 2'd1;
   localparam logic [1:0] REG_ACTIVE_WAYS  = 2'd2;
   localparam logic [1:0] REG_REPLACE_SEED = 2'd3;

   // register reset values and limits
   localparam logic [2:0]  OFFSET_RESET = 3'd4;
   localparam logic [3:0]  INDEX_RESET  = 4'd8;
   localparam logic [2:0]  WAYS_RESET   = 3'd4;
   localparam logic [15:0] SEED_RESET   = 16'd44257;
   localparam logic [2:0]  OFFSET_MIN   = 3'd2;
   localparam logic [2:0]  OFFSET_MAX   = 3'd6;

   // replacement lfsr
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam int LFSR_W    = 16;
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = LFSR_W / MOD_BITS;

   // outcome codes
   localparam logic [1:0] OUTCOME_HIT        = 2'd0;
   localparam logic [1:0] OUTCOME_COMPULSORY = 2'd1;
   localparam logic [1:0] OUTCOME_CONFLICT   = 2'd2;

   typedef struct packed {
      logic [31:0] address;
      logic [5:0]  length;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [7:0]  set_index;
      logic [1:0]  way;
      logic [6:0]  byte_credit;
      logic [6:0]  miss_cycles;
      logic [31:0] hit_total;
      logic [31:0] compulsory_total;
      logic [31:0] conflict_total;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  offset_bits;
      logic [3:0]  index_bits;
      logic [2:0]  active_ways;
      logic [15:0] replace_seed;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic [15:0] seed;
   } seed_load_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic lookup;
      logic conflict_start;
      logic mod_step;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic set_full;
      logic mod_done;
      logic last_block;
   } dp_sts_type;

   // one step of the galois lfsr
   function automatic logic [15:0] lfsr_step(input logic [15:0] value);
      logic [15:0] shifted;
      shifted = value >> 1;
      if (value[0]) begin
         shifted = shifted ^ LFSR_TAPS;
      end
      return shifted;
   endfunction

endpackage

`default_nettype wire

// ===== design/sacl_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds while not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sacl_csr.sv =====
// configuration registers behind the apb-style port
`default_nettype none

module sacl_csr (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [sacl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [sacl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [sacl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                     csr_pready,
   output sacl_pkg::cfg_type        cfg,
   output sacl_pkg::seed_load_type  seed_load
);
   import sacl_pkg::*;

   logic [1:0] reg_idx;
   logic       wr_xfer;
   cfg_type    cfg_ff;
   cfg_type    cfg_in;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_xfer    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_xfer) begin
         case (reg_idx)
            REG_OFFSET_BITS:  cfg_in.offset_bits  = csr_pwdata[2:0];
            REG_INDEX_BITS:   cfg_in.index_bits   = csr_pwdata[3:0];
            REG_ACTIVE_WAYS:  cfg_in.active_ways  = csr_pwdata[2:0];
            REG_REPLACE_SEED: cfg_in.replace_seed = csr_pwdata[15:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_bits  <= OFFSET_RESET;
         cfg_ff.index_bits   <= INDEX_RESET;
         cfg_ff.active_ways  <= WAYS_RESET;
         cfg_ff.replace_seed <= SEED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a seed write reloads the lfsr in the same transfer
   assign seed_load.load = wr_xfer && (reg_idx == REG_REPLACE_SEED);
   assign seed_load.seed = csr_pwdata[15:0];

   // read mux
   always_comb begin
      case (reg_idx)
         REG_OFFSET_BITS:  csr_prdata = CSR_DW'(cfg_ff.offset_bits);
         REG_INDEX_BITS:   csr_prdata = CSR_DW'(cfg_ff.index_bits);
         REG_ACTIVE_WAYS:  csr_prdata = CSR_DW'(cfg_ff.active_ways);
         REG_REPLACE_SEED: csr_prdata = CSR_DW'(cfg_ff.replace_seed);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/sacl_ctrl.sv =====
// lookup sequencer: clearing pass, per-block read, compare and commit
`default_nettype none

module sacl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sacl_pkg::dp_sts_type    sts,
   output sacl_pkg::ctl_cmd_type   cmd
);
   import sacl_pkg::*;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_MOD   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // output register can take a result this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.lookup = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            if (sts.set_full) begin
               cmd.conflict_start = 1'b1;
               state_in           = ST_MOD;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = sts.last_block ? ST_IDLE : ST_LOOK;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = sts.last_block ? ST_IDLE : ST_LOOK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result transfer flag
   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result committed over a pending transfer");

   // the final block of an access frees the input side
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && sts.last_block) |=> req_ready)
      else $error("input not ready after final block");

endmodule

`default_nettype wire

// ===== design/sacl_dp.sv =====
// datapath: block walk, tag store, replacement lfsr, counters, result register
`default_nettype none

module sacl_dp #(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 4,
   parameter int MAX_LENGTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sacl_pkg::ctl_cmd_type   cmd,
   output sacl_pkg::dp_sts_type    sts,
   input  sacl_pkg::cfg_type       cfg,
   input  sacl_pkg::seed_load_type seed_load,
   input  sacl_pkg::req_type       req_data,
   output sacl_pkg::rsp_type       rsp_data
);
   import sacl_pkg::*;

   localparam int SET_AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int MIB    = $clog2(MAX_SETS + 1) - 1;
   localparam int IB_MAX = (MIB < IDX_CAP) ? MIB : IDX_CAP;
   localparam int WIDX   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAYS_W = $clog2(MAX_WAYS + 1);
   localparam int ROW_W  = MAX_WAYS * ENTRY_W;
   localparam int MC_W   = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   // per-access registers
   logic [31:0]       blk_ff,  blk_in;
   logic [5:0]        off_ff,  off_in;
   logic [LEN_W-1:0]  rem_ff,  rem_in;
   logic [2:0]        ob_ff,   ob_in;
   logic [3:0]        ib_ff,   ib_in;
   logic [WAYS_W-1:0] ways_ff, ways_in;

   // lfsr and remainder unit
   logic [15:0]       lfsr_ff,    lfsr_in;
   logic [15:0]       mod_div_ff, mod_div_in;
   logic [WAYS_W-1:0] mod_rem_ff, mod_rem_in;
   logic [MC_W-1:0]   mod_cnt_ff, mod_cnt_in;

   // clearing pass and counters
   logic [SET_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [31:0]       hit_ff,  hit_in;
   logic [31:0]       comp_ff, comp_in;
   logic [31:0]       conf_ff, conf_in;
   rsp_type           rsp_ff,  rsp_in;

   // combinational block view
   logic [LEN_W-1:0]  len_c;
   logic [LEN_W-1:0]  bsize;
   logic [LEN_W-1:0]  n_raw;
   logic [LEN_W-1:0]  n_blk;
   logic [LEN_W-1:0]  rem_after;
   logic [7:0]        set8;
   logic [TAG_W-1:0]  tag;
   logic [ROW_W-1:0]  row;
   logic [ROW_W-1:0]  row_new;
   logic              found;
   logic              found_valid;
   logic [WIDX-1:0]   fw;
   logic [WIDX-1:0]   sel_way;
   logic              is_hit;
   logic              is_conflict;
   logic [LEN_W-1:0]  hit_add;
   logic              ram_wr_en;
   logic [SET_AW-1:0] ram_wr_addr;
   logic [ROW_W-1:0]  ram_wr_data;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // clamp configuration and length at item transfer
   always_comb begin
      if (cfg.offset_bits < OFFSET_MIN) begin
         ob_in = OFFSET_MIN;
      end else if (cfg.offset_bits > OFFSET_MAX) begin
         ob_in = OFFSET_MAX;
      end else begin
         ob_in = cfg.offset_bits;
      end
      if (int'(cfg.index_bits) > IB_MAX) begin
         ib_in = 4'(IB_MAX);
      end else begin
         ib_in = cfg.index_bits;
      end
      if (cfg.active_ways == 3'd0) begin
         ways_in = WAYS_W'(1);
      end else if (int'(cfg.active_ways) > MAX_WAYS) begin
         ways_in = WAYS_W'(MAX_WAYS);
      end else begin
         ways_in = WAYS_W'(cfg.active_ways);
      end
      len_c = (req_data.length == 6'd0) ? LEN_W'(1) : LEN_W'(req_data.length);
      if (int'(len_c) > MAX_LENGTH) begin
         len_c = LEN_W'(MAX_LENGTH);
      end
   end

   // bytes of this block inside the access
   assign bsize     = LEN_W'(1) << ob_ff;
   assign n_raw     = bsize - LEN_W'(off_ff);
   assign n_blk     = (n_raw > rem_ff) ? rem_ff : n_raw;
   assign rem_after = rem_ff - n_blk;

   // set and tag of the current block
   assign set8 = blk_ff[7:0] & ~(8'hFF << ib_ff);
   assign tag  = TAG_W'(blk_ff >> ib_ff);

   // way scan: first way holding the tag or empty
   always_comb begin
      logic [ENTRY_W-1:0] e;
      found       = 1'b0;
      found_valid = 1'b0;
      fw          = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         e = row[w*ENTRY_W +: ENTRY_W];
         if (!found && (WAYS_W'(w) < ways_ff)) begin
            if (!e[ENTRY_W-1] || (e[TAG_W-1:0] == tag)) begin
               found       = 1'b1;
               found_valid = e[ENTRY_W-1];
               fw          = WIDX'(w);
            end
         end
      end
   end

   assign is_hit      = found && found_valid;
   assign is_conflict = !found;
   assign sel_way     = is_conflict ? WIDX'(mod_rem_ff) : fw;

   // row with the chosen way refilled
   always_comb begin
      row_new = row;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (WIDX'(w) == sel_way) begin
            row_new[w*ENTRY_W +: ENTRY_W] = {1'b1, tag};
         end
      end
   end

   // tag store write port: clearing pass or miss refill
   always_comb begin
      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = cmd.commit && !is_hit;
         ram_wr_addr = SET_AW'(set8);
         ram_wr_data = row_new;
      end
   end

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (SET_AW'(set8)),
      .rd_data (row)
   );

   // remainder of the stepped lfsr by the way count, a few bits a cycle
   always_comb begin
      logic [WAYS_W:0] r;
      logic [15:0]     d;
      r = {1'b0, mod_rem_ff};
      d = mod_div_ff;
      for (int i = 0; i < MOD_BITS; i++) begin
         r = {r[WAYS_W-1:0], d[15]};
         d = d << 1;
         if (r >= {1'b0, ways_ff}) begin
            r = r - {1'b0, ways_ff};
         end
      end
      mod_rem_in = mod_rem_ff;
      mod_div_in = mod_div_ff;
      mod_cnt_in = mod_cnt_ff;
      lfsr_in    = lfsr_ff;
      if (seed_load.load) begin
         lfsr_in = (seed_load.seed == '0) ? 16'd1 : seed_load.seed;
      end else if (cmd.conflict_start) begin
         lfsr_in    = lfsr_step(lfsr_ff);
         mod_div_in = lfsr_step(lfsr_ff);
         mod_rem_in = '0;
         mod_cnt_in = '0;
      end else if (cmd.mod_step) begin
         mod_rem_in = r[WAYS_W-1:0];
         mod_div_in = d;
         mod_cnt_in = mod_cnt_ff + MC_W'(1);
      end
   end

   // result and running counters
   always_comb begin
      hit_add = is_hit ? LEN_W'(1) : (n_blk - LEN_W'(1));
      hit_in  = sat_add(hit_ff, 32'(hit_add));
      comp_in = sat_add(comp_ff, {31'd0, found && !found_valid});
      conf_in = sat_add(conf_ff, {31'd0, is_conflict});
      rsp_in.set_index        = set8;
      rsp_in.way              = 2'(sel_way);
      rsp_in.hit_total        = hit_in;
      rsp_in.compulsory_total = comp_in;
      rsp_in.conflict_total   = conf_in;
      rsp_in.last             = (rem_after == '0);
      if (is_hit) begin
         rsp_in.outcome     = OUTCOME_HIT;
         rsp_in.byte_credit = 7'd1;
         rsp_in.miss_cycles = 7'd1;
      end else if (is_conflict) begin
         rsp_in.outcome     = OUTCOME_CONFLICT;
         rsp_in.byte_credit = 7'(bsize);
         rsp_in.miss_cycles = 7'd0;
      end else begin
         rsp_in.outcome     = OUTCOME_COMPULSORY;
         rsp_in.byte_credit = 7'd1;
         rsp_in.miss_cycles = 7'(bsize);
      end
   end

   // block walk
   always_comb begin
      blk_in = blk_ff;
      off_in = off_ff;
      rem_in = rem_ff;
      if (cmd.accept) begin
         blk_in = req_data.address >> ob_in;
         off_in = req_data.address[5:0] & ~(6'h3F << ob_in);
         rem_in = len_c;
      end else if (cmd.commit) begin
         blk_in = (blk_ff + 32'd1) & (32'hFFFF_FFFF >> ob_ff);
         off_in = '0;
         rem_in = rem_after;
      end
   end

   assign clr_cnt_in = cmd.clear ? (clr_cnt_ff + SET_AW'(1)) : clr_cnt_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff    <= SEED_RESET;
         mod_cnt_ff <= '0;
         clr_cnt_ff <= '0;
         hit_ff     <= '0;
         comp_ff    <= '0;
         conf_ff    <= '0;
      end else begin
         lfsr_ff    <= lfsr_in;
         mod_cnt_ff <= mod_cnt_in;
         clr_cnt_ff <= clr_cnt_in;
         if (cmd.commit) begin
            hit_ff  <= hit_in;
            comp_ff <= comp_in;
            conf_ff <= conf_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      blk_ff     <= blk_in;
      off_ff     <= off_in;
      rem_ff     <= rem_in;
      mod_div_ff <= mod_div_in;
      mod_rem_ff <= mod_rem_in;
      if (cmd.accept) begin
         ob_ff   <= ob_in;
         ib_ff   <= ib_in;
         ways_ff <= ways_in;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data       = rsp_ff;
   assign sts.clear_done = (clr_cnt_ff == SET_AW'(MAX_SETS - 1));
   assign sts.set_full   = is_conflict;
   assign sts.mod_done   = (mod_cnt_ff == MC_W'(MOD_STEPS - 1));
   assign sts.last_block = (rem_after == '0);

   // the lfsr never locks up at zero
   assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("replacement lfsr reached zero");

   // a replaced way lies among the active ways
   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && sts.set_full) |-> (mod_rem_ff < ways_ff))
      else $error("replacement way outside active ways");

   // a lookup is only issued while bytes of the access remain
   assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |-> (rem_ff != '0))
      else $error("lookup with no bytes left");

endmodule

`default_nettype wire

// ===== design/set_assoc_cache_lookup.sv =====
// Set-associative cache lookup with random replacement, top level.
//
// An access (address, length) is taken on the req_ channel and split into
// the cache blocks it touches; every block gives one result transfer on the
// rsp_ channel, the last one flagged by last. Configuration is written
// through the csr_ port while no access is in flight; the user is bound to that, the block itself does not enforce it.
//
// Sequence: an access is taken, then each block needs a tag store row read
// followed by the compare and, on a miss, the write-back. A conflict miss
// adds the lfsr step and the way pick (remainder by the way count, four bits
// a cycle) before the write-back. A new access is taken once the last block
// of the previous one commits.
//
// After reset the tag store is cleared one set row a cycle, until every row
// is empty, with req_ready low; csr writes are taken during that time.
// Results sit in an output register; when rsp_ready is low the lookup of
// the next block finishes and waits until the register frees up.
`default_nettype none

module set_assoc_cache_lookup #(
   parameter int MAX_SETS   = 256,
   parameter int MAX_WAYS   = 4,
   parameter int MAX_LENGTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sacl_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sacl_pkg::rsp_type           rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [sacl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [sacl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [sacl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import sacl_pkg::*;

   cfg_type       cfg;
   seed_load_type seed_load;
   ctl_cmd_type   cmd;
   dp_sts_type    sts;

   // configuration registers
   sacl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .seed_load   (seed_load)
   );

   // sequencer
   sacl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath with tag store
   sacl_dp #(
      .MAX_SETS   (MAX_SETS),
      .MAX_WAYS   (MAX_WAYS),
      .MAX_LENGTH (MAX_LENGTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .cfg       (cfg),
      .seed_load (seed_load),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// self-checking testbench of the set-associative cache lookup
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sacl_pkg::*;

   localparam int MAX_SETS    = 256;
   localparam int MAX_WAYS    = 4;
   localparam int MAX_LENGTH  = 32;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 49;
   localparam int LONG_HOLD   = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;

   // tracks tag store, counters and lfsr; holds the block results still due
   class lookup_scoreboard;
      cfg_type              cfg;
      logic [ENTRY_W-1:0]   tags [MAX_SETS*MAX_WAYS];
      logic [31:0]          hits;
      logic [31:0]          compulsories;
      logic [31:0]          conflicts;
      logic [15:0]          lfsr;
      rsp_type              expected_blocks [$];
      int unsigned          errors;

      function new();
         cfg.offset_bits  = OFFSET_RESET;
         cfg.index_bits   = INDEX_RESET;
         cfg.active_ways  = WAYS_RESET;
         cfg.replace_seed = SEED_RESET;
         lfsr = SEED_RESET;
         foreach (tags[i]) tags[i] = '0;
         hits = '0;
         compulsories = '0;
         conflicts = '0;
         errors = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_OFFSET_BITS:  cfg.offset_bits = value[2:0];
            REG_INDEX_BITS:   cfg.index_bits = value[3:0];
            REG_ACTIVE_WAYS:  cfg.active_ways = value[2:0];
            REG_REPLACE_SEED: begin
               cfg.replace_seed = value[15:0];
               // an all-zero seed would lock the lfsr up
               lfsr = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
            end
            default: ;
         endcase
      endfunction

      // effective block size bits after clamping
      function int unsigned block_bits();
         if (cfg.offset_bits < OFFSET_MIN) return OFFSET_MIN;
         if (cfg.offset_bits > OFFSET_MAX) return OFFSET_MAX;
         return cfg.offset_bits;
      endfunction

      function int unsigned set_bits();
         return (cfg.index_bits > IDX_CAP) ? IDX_CAP : cfg.index_bits;
      endfunction

      function int unsigned way_count();
         if (cfg.active_ways == 3'd0) return 1;
         if (cfg.active_ways > MAX_WAYS) return MAX_WAYS;
         return cfg.active_ways;
      endfunction

      function logic [31:0] saturate(logic [31:0] a, logic [31:0] b);
         logic [32:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      endfunction

      function int pending();
         return expected_blocks.size();
      endfunction

      // accepted access: split into blocks and work out each block result
      function void predict_access(req_type item);
         int unsigned ob, ib, ways, remaining, bsize, off, n, w, base, pick, credit, cyc;
         logic [31:0] blk, blkmask, set_no;
         logic [TAG_W-1:0] tag;
         logic found;
         rsp_type r;
         ob = block_bits();
         ib = set_bits();
         ways = way_count();
         remaining = item.length;
         if (remaining == 0) remaining = 1;
         if (remaining > MAX_LENGTH) remaining = MAX_LENGTH;
         bsize = 1 << ob;
         blkmask = 32'hFFFF_FFFF >> ob;
         blk = item.address >> ob;
         off = item.address & (bsize - 1);
         while (remaining > 0) begin
            n = bsize - off;
            if (n > remaining) n = remaining;
            set_no = blk & ((32'd1 << ib) - 32'd1);
            tag = TAG_W'(blk >> ib);
            base = set_no * MAX_WAYS;
            found = 1'b0;
            r = '0;
            r.outcome = OUTCOME_CONFLICT;
            // first way holding the tag or empty ends the scan
            for (w = 0; w < ways && !found; w++) begin
               if (tags[base+w][TAG_W] && tags[base+w][TAG_W-1:0] == tag) begin
                  r.outcome = OUTCOME_HIT;
                  r.way = w[1:0];
                  found = 1'b1;
               end else if (!tags[base+w][TAG_W]) begin
                  tags[base+w] = {1'b1, tag};
                  r.outcome = OUTCOME_COMPULSORY;
                  r.way = w[1:0];
                  found = 1'b1;
               end
            end
            case (r.outcome)
               OUTCOME_HIT: begin
                  hits = saturate(hits, 32'd1);
                  credit = 1;
                  cyc = 1;
               end
               OUTCOME_COMPULSORY: begin
                  compulsories = saturate(compulsories, 32'd1);
                  hits = saturate(hits, n - 1);
                  credit = 1;
                  cyc = bsize;
               end
               default: begin
                  conflicts = saturate(conflicts, 32'd1);
                  hits = saturate(hits, n - 1);
                  // galois step, then pick a way from the new value
                  lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
                  pick = lfsr % ways;
                  tags[base+pick] = {1'b1, tag};
                  r.way = pick[1:0];
                  credit = bsize;
                  cyc = 0;
               end
            endcase
            remaining -= n;
            off = 0;
            blk = (blk + 32'd1) & blkmask;
            r.set_index = set_no[7:0];
            r.byte_credit = credit[6:0];
            r.miss_cycles = cyc[6:0];
            r.hit_total = hits;
            r.compulsory_total = compulsories;
            r.conflict_total = conflicts;
            r.last = (remaining == 0);
            expected_blocks.push_back(r);
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s expected %0d got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_block(rsp_type got);
         rsp_type want;
         if (expected_blocks.size() == 0) begin
            $error("result transfer with no block expected");
            errors++;
            return;
         end
         want = expected_blocks.pop_front();
         compare_field("outcome", want.outcome, got.outcome);
         compare_field("set_index", want.set_index, got.set_index);
         compare_field("way", want.way, got.way);
         compare_field("byte_credit", want.byte_credit, got.byte_credit);
         compare_field("miss_cycles", want.miss_cycles, got.miss_cycles);
         compare_field("hit_total", want.hit_total, got.hit_total);
         compare_field("compulsory_total", want.compulsory_total, got.compulsory_total);
         compare_field("conflict_total", want.conflict_total, got.conflict_total);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   lookup_scoreboard    sb = new();
   logic                req_idle_on = 1'b1;
   logic                rsp_idle_on = 1'b1;
   logic                hold_request = 1'b0;
   int unsigned         quiet_cycles = 0;

   set_assoc_cache_lookup uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         sb.check_block(rsp_data);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // result receiver: random stall bursts and one long hold-off on request
   initial begin
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // one register write: setup then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.write_register(idx, value);
      @(posedge clock);
   endtask

   // offer one access and hold it until the transfer
   task automatic send_access(input logic [31:0] address, input logic [5:0] length);
      req_type item;
      item.address = address;
      item.length = length;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.predict_access(item);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // register settings per phase, out-of-range values among them
   function automatic cfg_type phase_setting(int phase);
      cfg_type s;
      s.replace_seed = 16'($urandom_range(1, 65535));
      case (phase)
         0: begin s.offset_bits = 3'd0; s.index_bits = 4'd15; s.active_ways = 3'd0;
                  s.replace_seed = 16'h0000; end
         1: begin s.offset_bits = 3'd2; s.index_bits = 4'd0;  s.active_ways = 3'd1;
                  s.replace_seed = 16'hFFFF; end
         2: begin s.offset_bits = 3'd6; s.index_bits = 4'd8;  s.active_ways = 3'd4; end
         3: begin s.offset_bits = 3'd7; s.index_bits = 4'd9;  s.active_ways = 3'd7; end
         4: begin s.offset_bits = 3'd1; s.index_bits = 4'd4;  s.active_ways = 3'd5; end
         5: begin s.offset_bits = 3'd3; s.index_bits = 4'd2;  s.active_ways = 3'd2; end
         6: begin s.offset_bits = 3'd5; s.index_bits = 4'd6;  s.active_ways = 3'd6; end
         default: begin s.offset_bits = 3'd4; s.index_bits = 4'd1; s.active_ways = 3'd3; end
      endcase
      return s;
   endfunction

   // mostly a few hot tags over a few sets so hits and conflicts happen
   task automatic send_random_access();
      logic [31:0] address;
      logic [5:0]  length;
      int unsigned roll, span;
      roll = $urandom_range(0, 9);
      span = sb.block_bits() + sb.set_bits();
      if (roll < 7) begin
         address = ($urandom_range(0, 5) << span) |
                   ($urandom_range(0, 3) << sb.block_bits()) | $urandom_range(0, 63);
      end else if (roll == 7) begin
         address = 32'hFFFF_FFFF - $urandom_range(0, 40);
      end else begin
         address = $urandom();
      end
      if ($urandom_range(0, 9) < 8) begin
         length = 6'($urandom_range(1, MAX_LENGTH));
      end else begin
         length = 6'($urandom_range(0, 63));
      end
      send_access(address, length);
   endtask

   initial begin
      cfg_type setting;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset settings: 16 byte blocks, 256 sets, 4 ways
      send_access(32'h0000_0000, 6'd1);
      send_access(32'h0000_0000, 6'd1);
      send_access(32'h0000_0000, 6'd0);
      send_access(32'h0000_0003, 6'd63);
      send_access(32'h0000_100F, 6'd2);
      send_access(32'hFFFF_FFF0, 6'd32);
      send_access(32'hFFFF_FFFF, 6'd33);
      // six tags into one set: four fills then replacements
      for (int k = 1; k <= 6; k++) begin
         send_access((k << 12) | 32'h50, 6'd16);
      end
      send_access(32'h0000_1050, 6'd16);
      send_access(32'h0000_6050, 6'd1);
      send_access(32'h0000_0208, 6'd32);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         setting = phase_setting(phase);
         csr_write(REG_OFFSET_BITS, 32'(setting.offset_bits));
         csr_write(REG_INDEX_BITS, 32'(setting.index_bits));
         csr_write(REG_ACTIVE_WAYS, 32'(setting.active_ways));
         csr_write(REG_REPLACE_SEED, 32'(setting.replace_seed));
         // no idling in the plain phase and in the closing phase
         req_idle_on = !(phase == 2 || phase == PHASES - 1);
         rsp_idle_on = !(phase == 2 || phase == PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver hold-off while accesses keep coming
            if (phase == 3 && i == 10) hold_request = 1'b1;
            // sender pause until all results are back
            if (phase == 4 && i == 20) wait_drained();
            send_random_access();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_csr.sv
design/sacl_ctrl.sv
design/sacl_dp.sv
design/set_assoc_cache_lookup.sv
bench/testbench.sv
